// ===== hw/rtl/jbwf_pkg.sv =====
// ----------------------------------------------------------------------------
// Jitter buffer package
// Sizes, codes and shared types of the watermark jitter buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package jbwf_pkg;

    localparam int CAPACITY   = 256;
    localparam int SAMPLE_W   = 16;
    localparam int MAX_UNIT   = 64;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int UNIT_W     = 7;
    localparam int MARK_W     = 9;
    localparam int METER_W    = 16;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_IDX_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STANDBY  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNDERRUN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_POLICY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FLUSH    = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_METER_LIMIT = 3'd4;

    localparam logic [UNIT_W-1:0]  RST_UNIT_SIZE   = 7'd16;
    localparam logic [MARK_W-1:0]  RST_HIGH_MARK   = 9'd128;
    localparam logic [MARK_W-1:0]  RST_START_MARK  = 9'd64;
    localparam logic [MARK_W-1:0]  RST_LOW_MARK    = 9'd32;
    localparam logic [METER_W-1:0] RST_METER_LIMIT = 16'd512;

    typedef struct packed {
        logic [UNIT_W-1:0]  unit_size;
        logic [MARK_W-1:0]  high_mark;
        logic [MARK_W-1:0]  start_mark;
        logic [MARK_W-1:0]  low_mark;
        logic [METER_W-1:0] meter_limit;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]   op;
        logic [SAMPLE_W-1:0] sample;
        logic                burst_last;
    } cmd_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [STATUS_W-1:0] status;
        logic                last;
        logic [CNT_W-1:0]    fill;
    } rsp_t;

    function automatic logic [METER_W-1:0] meter_add(input logic [METER_W-1:0] m,
                                                      input logic [CNT_W-1:0] v);
        logic [METER_W:0] s;
        s = {1'b0, m} + (METER_W + 1)'(v);
        return s[METER_W] ? {METER_W{1'b1}} : s[METER_W-1:0];
    endfunction

    function automatic logic [UNIT_W-1:0] clamp_unit(input logic [UNIT_W-1:0] v);
        logic [UNIT_W-1:0] r;
        if (v == '0)
            r = UNIT_W'(1);
        else if (v > UNIT_W'(MAX_UNIT))
            r = UNIT_W'(MAX_UNIT);
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jbwf_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one write, read or flush request per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface jbwf_req_if;
    logic                          valid;
    logic                          ready;
    logic [jbwf_pkg::MODE_W-1:0]   mode;
    logic [jbwf_pkg::SAMPLE_W-1:0] sample;
    logic                          burst_last;

    modport source (output valid, output mode, output sample, output burst_last,
                    input ready);
    modport sink   (input valid, input mode, input sample, input burst_last,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/jbwf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result sample with its status per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface jbwf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [jbwf_pkg::SAMPLE_W-1:0] sample_out;
    logic [jbwf_pkg::STATUS_W-1:0] status;
    logic                          last;
    logic [jbwf_pkg::CNT_W-1:0]    fill_level;

    modport source (output valid, output sample_out, output status, output last,
                    output fill_level, input ready);
    modport sink   (input valid, input sample_out, input status, input last,
                    input fill_level, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/jbwf_front.sv =====
// ----------------------------------------------------------------------------
// Request front end
// Accepts request words, drops unused modes and forms queue commands.
// ----------------------------------------------------------------------------
`default_nettype none

module jbwf_front (
    jbwf_req_if.sink          req,
    input  wire logic         q_full,
    output logic              q_push,
    output jbwf_pkg::cmd_t    q_cmd
);

    logic known;

    always_comb
    begin
        unique case (req.mode)
            jbwf_pkg::MODE_WRITE,
            jbwf_pkg::MODE_READ,
            jbwf_pkg::MODE_FLUSH: known = 1'b1;
            default:              known = 1'b0;
        endcase
    end

    assign req.ready           = !q_full;
    assign q_push              = req.valid && !q_full && known;
    assign q_cmd.op            = req.mode;
    assign q_cmd.sample        = req.sample;
    assign q_cmd.burst_last    = req.burst_last;

endmodule

`default_nettype wire

// ===== hw/rtl/jbwf_cmdq.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Short queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jbwf_cmdq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire jbwf_pkg::cmd_t push_cmd,
    output logic                full,
    output logic                valid,
    output jbwf_pkg::cmd_t      head,
    input  wire logic           pop
);

    jbwf_pkg::cmd_t                      q_reg [jbwf_pkg::CMDQ_DEPTH];
    logic [jbwf_pkg::CMDQ_IDX_W-1:0]     wr_reg;
    logic [jbwf_pkg::CMDQ_IDX_W-1:0]     rd_reg;
    logic [jbwf_pkg::CMDQ_CNT_W-1:0]     cnt_reg;
    logic [jbwf_pkg::CMDQ_CNT_W-1:0]     cnt_next;
    logic                                do_pop;

    assign full   = cnt_reg == jbwf_pkg::CMDQ_CNT_W'(jbwf_pkg::CMDQ_DEPTH);
    assign valid  = cnt_reg != '0;
    assign head   = q_reg[rd_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/jbwf_back.sv =====
// ----------------------------------------------------------------------------
// Execution back end
// Holds the sample store and watermark state, runs commands and queues results.
// ----------------------------------------------------------------------------
`default_nettype none

module jbwf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire jbwf_pkg::cfg_t cfg,
    input  wire logic           cmd_valid,
    input  wire jbwf_pkg::cmd_t cmd,
    output logic                cmd_pop,
    jbwf_rsp_if.source          rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_UNIT = 1'b1;

    localparam int CAP = jbwf_pkg::CAPACITY;
    localparam int AW  = jbwf_pkg::ADDR_W;
    localparam int CW  = jbwf_pkg::CNT_W;
    localparam int UW  = jbwf_pkg::UNIT_W;
    localparam int MW  = jbwf_pkg::METER_W;
    localparam int SW  = jbwf_pkg::STATUS_W;

    logic [jbwf_pkg::SAMPLE_W-1:0] mem [CAP];
    logic [jbwf_pkg::SAMPLE_W-1:0] mem_q;

    logic          state_reg,   state_next;
    logic [CW-1:0] count_reg,   count_next;
    logic [AW-1:0] rd_ptr_reg,  rd_ptr_next;
    logic [AW-1:0] wr_ptr_reg,  wr_ptr_next;
    logic          ready_reg,   ready_next;
    logic          ba_reg,      ba_next;
    logic          dp_reg,      dp_next;
    logic [MW-1:0] dmeter_reg,  dmeter_next;
    logic [MW-1:0] imeter_reg,  imeter_next;
    logic [UW-1:0] unit_reg,    unit_next;
    logic [UW-1:0] take_reg,    take_next;
    logic [UW-1:0] idx_reg,     idx_next;
    logic          fmode_reg,   fmode_next;
    logic [SW-1:0] fst_reg,     fst_next;

    logic          s1_valid_reg;
    logic          s1_mem_reg;
    logic [SW-1:0] s1_status_reg;
    logic          s1_last_reg;
    logic [CW-1:0] s1_fill_reg;

    jbwf_pkg::rsp_t oq_reg [2];
    logic           oq_wr_reg;
    logic           oq_rd_reg;
    logic [1:0]     oq_cnt_reg;

    logic          pop;
    logic          credit;
    logic          emit;
    logic          emit_mem;
    logic [SW-1:0] emit_status;
    logic          emit_last;
    logic [CW-1:0] emit_fill;
    logic          mem_we;
    logic          mem_re;
    logic [UW-1:0] unit_c;
    logic [UW-1:0] idx_inc;
    logic [MW-1:0] dsum;
    logic [MW-1:0] isum;
    jbwf_pkg::rsp_t push_rsp;

    assign pop    = rsp.valid && rsp.ready;
    assign credit = ({1'b0, oq_cnt_reg} + {2'b00, s1_valid_reg}) <= (3'd1 + {2'b00, pop});
    assign unit_c = jbwf_pkg::clamp_unit(cfg.unit_size);
    assign idx_inc = idx_reg + 1'b1;

    assign rsp.valid      = oq_cnt_reg != 2'd0;
    assign rsp.sample_out = oq_reg[oq_rd_reg].sample;
    assign rsp.status     = oq_reg[oq_rd_reg].status;
    assign rsp.last       = oq_reg[oq_rd_reg].last;
    assign rsp.fill_level = oq_reg[oq_rd_reg].fill;

    assign push_rsp.sample = s1_mem_reg ? mem_q : '0;
    assign push_rsp.status = s1_status_reg;
    assign push_rsp.last   = s1_last_reg;
    assign push_rsp.fill   = s1_fill_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        ready_next  = ready_reg;
        ba_next     = ba_reg;
        dp_next     = dp_reg;
        dmeter_next = dmeter_reg;
        imeter_next = imeter_reg;
        unit_next   = unit_reg;
        take_next   = take_reg;
        idx_next    = idx_reg;
        fmode_next  = fmode_reg;
        fst_next    = fst_reg;
        cmd_pop     = 1'b0;
        emit        = 1'b0;
        emit_mem    = 1'b0;
        emit_status = jbwf_pkg::ST_OK;
        emit_last   = 1'b0;
        emit_fill   = count_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        dsum        = '0;
        isum        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && credit)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        jbwf_pkg::MODE_WRITE:
                        begin
                            if (!ba_reg)
                            begin
                                dp_next = 1'b0;
                                if (count_reg >= cfg.high_mark)
                                begin
                                    dsum = jbwf_pkg::meter_add(dmeter_reg, count_reg);
                                    if (dsum >= cfg.meter_limit)
                                    begin
                                        dmeter_next = '0;
                                        dp_next     = 1'b1;
                                    end
                                    else
                                    begin
                                        dmeter_next = dsum;
                                    end
                                end
                                else
                                begin
                                    dmeter_next = '0;
                                end
                            end
                            priority if (cmd.burst_last && dp_next)
                            begin
                                emit_status = jbwf_pkg::ST_POLICY;
                            end
                            else if (count_reg >= CW'(CAP))
                            begin
                                emit_status = jbwf_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                wr_ptr_next = (wr_ptr_reg == AW'(CAP - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
                                count_next  = count_reg + 1'b1;
                            end
                            if (cmd.burst_last)
                            begin
                                ba_next = 1'b0;
                                dp_next = 1'b0;
                                if (count_next >= cfg.start_mark)
                                    ready_next = 1'b1;
                            end
                            else
                            begin
                                ba_next = 1'b1;
                            end
                            emit      = 1'b1;
                            emit_last = 1'b1;
                            emit_fill = count_next;
                        end
                        jbwf_pkg::MODE_READ:
                        begin
                            unit_next  = unit_c;
                            idx_next   = '0;
                            take_next  = unit_c;
                            state_next = S_UNIT;
                            if (!ready_reg || count_reg < CW'(unit_c))
                            begin
                                fmode_next = 1'b1;
                                fst_next   = ready_reg ? jbwf_pkg::ST_UNDERRUN
                                                       : jbwf_pkg::ST_STANDBY;
                                if (ready_reg)
                                begin
                                    ready_next  = 1'b0;
                                    imeter_next = '0;
                                end
                            end
                            else
                            begin
                                fmode_next = 1'b0;
                                if (count_reg < cfg.low_mark)
                                begin
                                    isum = jbwf_pkg::meter_add(imeter_reg, CW'(unit_c));
                                    if (isum >= cfg.meter_limit)
                                    begin
                                        imeter_next = '0;
                                        take_next   = unit_c - 1'b1;
                                    end
                                    else
                                    begin
                                        imeter_next = isum;
                                    end
                                end
                                else
                                begin
                                    imeter_next = '0;
                                end
                            end
                        end
                        jbwf_pkg::MODE_FLUSH:
                        begin
                            count_next  = '0;
                            rd_ptr_next = '0;
                            wr_ptr_next = '0;
                            ready_next  = 1'b0;
                            ba_next     = 1'b0;
                            dp_next     = 1'b0;
                            dmeter_next = '0;
                            imeter_next = '0;
                            emit        = 1'b1;
                            emit_status = jbwf_pkg::ST_FLUSH;
                            emit_last   = 1'b1;
                            emit_fill   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_UNIT:
            begin
                if (credit)
                begin
                    emit      = 1'b1;
                    idx_next  = idx_inc;
                    emit_last = idx_inc == unit_reg;
                    priority if (fmode_reg)
                    begin
                        emit_status = fst_reg;
                    end
                    else if (idx_reg < take_reg)
                    begin
                        mem_re      = 1'b1;
                        emit_mem    = 1'b1;
                        rd_ptr_next = (rd_ptr_reg == AW'(CAP - 1)) ? '0 : rd_ptr_reg + 1'b1;
                        count_next  = count_reg - 1'b1;
                        emit_fill   = count_next;
                    end
                    else
                    begin
                        emit_status = jbwf_pkg::ST_INSERT;
                    end
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                        if (!fmode_reg && count_next < CW'(unit_reg))
                        begin
                            ready_next  = 1'b0;
                            imeter_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            ready_reg    <= 1'b0;
            ba_reg       <= 1'b0;
            dp_reg       <= 1'b0;
            dmeter_reg   <= '0;
            imeter_reg   <= '0;
            unit_reg     <= '0;
            take_reg     <= '0;
            idx_reg      <= '0;
            fmode_reg    <= 1'b0;
            fst_reg      <= jbwf_pkg::ST_OK;
            s1_valid_reg <= 1'b0;
            oq_wr_reg    <= 1'b0;
            oq_rd_reg    <= 1'b0;
            oq_cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            ready_reg    <= ready_next;
            ba_reg       <= ba_next;
            dp_reg       <= dp_next;
            dmeter_reg   <= dmeter_next;
            imeter_reg   <= imeter_next;
            unit_reg     <= unit_next;
            take_reg     <= take_next;
            idx_reg      <= idx_next;
            fmode_reg    <= fmode_next;
            fst_reg      <= fst_next;
            s1_valid_reg <= emit;
            if (s1_valid_reg)
                oq_wr_reg <= ~oq_wr_reg;
            if (pop)
                oq_rd_reg <= ~oq_rd_reg;
            oq_cnt_reg   <= oq_cnt_reg + {1'b0, s1_valid_reg} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_ptr_reg] <= cmd.sample;
        if (mem_re)
            mem_q <= mem[rd_ptr_reg];
        s1_mem_reg    <= emit_mem;
        s1_status_reg <= emit_status;
        s1_last_reg   <= emit_last;
        s1_fill_reg   <= emit_fill;
        if (s1_valid_reg)
            oq_reg[oq_wr_reg] <= push_rsp;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/jitter_buffer_watermark_fifo.sv =====
// ----------------------------------------------------------------------------
// Watermark jitter buffer
// Sample FIFO with start, high and low marks, drop and insert metering.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  req     | in  | valid / ready    | mode, sample, burst_last
//  rsp     | out | valid / ready    | sample_out, status, last, fill_level
//  cfg     | in  | cfg_we (no wait) | cfg_index, cfg_data
//
//  Write and flush: one result word each from the back end.
//  Read: a decision step, then unit_size results, one per cycle while the
//  output queue has room (unit_size held to 1..64), paced by the sample store's
//  single read port. Results pass a registered store read stage and a two-word
//  output queue; sample reads issue only when that queue has room, so rsp
//  stalls hold them. Reset clears control state only, not the sample store.
// ----------------------------------------------------------------------------
`default_nettype none

module jitter_buffer_watermark_fifo (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [jbwf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [jbwf_pkg::CFG_DATA_W-1:0]  cfg_data,
    jbwf_req_if.sink                              req,
    jbwf_rsp_if.source                            rsp
);

    jbwf_pkg::cfg_t cfg_reg;
    jbwf_pkg::cmd_t q_cmd;
    jbwf_pkg::cmd_t q_head;
    logic           q_push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_size   <= jbwf_pkg::RST_UNIT_SIZE;
            cfg_reg.high_mark   <= jbwf_pkg::RST_HIGH_MARK;
            cfg_reg.start_mark  <= jbwf_pkg::RST_START_MARK;
            cfg_reg.low_mark    <= jbwf_pkg::RST_LOW_MARK;
            cfg_reg.meter_limit <= jbwf_pkg::RST_METER_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                jbwf_pkg::CFG_UNIT_SIZE:
                    cfg_reg.unit_size   <= cfg_data[jbwf_pkg::UNIT_W-1:0];
                jbwf_pkg::CFG_HIGH_MARK:
                    cfg_reg.high_mark   <= cfg_data[jbwf_pkg::MARK_W-1:0];
                jbwf_pkg::CFG_START_MARK:
                    cfg_reg.start_mark  <= cfg_data[jbwf_pkg::MARK_W-1:0];
                jbwf_pkg::CFG_LOW_MARK:
                    cfg_reg.low_mark    <= cfg_data[jbwf_pkg::MARK_W-1:0];
                jbwf_pkg::CFG_METER_LIMIT:
                    cfg_reg.meter_limit <= cfg_data[jbwf_pkg::METER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    jbwf_front u_front (
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_cmd)
    );

    jbwf_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head),
        .pop      (q_pop)
    );

    jbwf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (q_valid),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .rsp       (rsp)
    );

    a_unused_mode_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.mode == jbwf_pkg::MODE_UNUSED) |-> !q_push)
        else $error("unused mode entered the command queue");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == jbwf_pkg::ST_FLUSH) |-> rsp.fill_level == '0)
        else $error("flush result with nonzero fill");

    a_zero_on_non_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != jbwf_pkg::ST_OK) |-> rsp.sample_out == '0)
        else $error("nonzero sample on a non-ok result");

    a_insert_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == jbwf_pkg::ST_INSERT) |-> rsp.last)
        else $error("inserted zero not at end of unit");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.fill_level <= jbwf_pkg::CNT_W'(jbwf_pkg::CAPACITY))
        else $error("fill level above capacity");

endmodule

`default_nettype wire
